FILE: src/ordered_key_value_table_assert.svh
// Assertion macros shared by the ordered key/value table RTL.
// Each macro expands to one labeled concurrent assertion on clk, disabled in rst.
`ifndef ORDERED_KEY_VALUE_TABLE_ASSERT_SVH
`define ORDERED_KEY_VALUE_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OKVT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered_key_value_table assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define OKVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered_key_value_table assertion failed");

`endif

FILE: src/okvt_pkg.sv
// Shared sizes, types and action codes of the ordered key/value table.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package okvt_pkg;

  localparam int CAPACITY    = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int ACTION_W      = 3;
  localparam int KEY_FIELD_W   = 32;
  localparam int VALUE_FIELD_W = 32;
  localparam int POS_FIELD_W   = 4;
  localparam int COUNT_FIELD_W = 5;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_FIELD_W) ? CNT_W : POS_FIELD_W;

  typedef logic [KEY_WIDTH-1:0]   key_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [SLOT_W-1:0]      slot_idx_t;
  typedef logic [CAPACITY-1:0]    slot_mask_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT           = 0,
    ACT_UPDATE           = 1,
    ACT_INSERT_OR_UPDATE = 2,
    ACT_ERASE            = 3,
    ACT_CONTAINS         = 4,
    ACT_GET_BY_KEY       = 5,
    ACT_GET_BY_POSITION  = 6
  } action_t;

endpackage

`default_nettype wire

FILE: src/okvt_req_if.sv
// Request channel of the ordered key/value table: valid/ready plus one item.
// Depends on okvt_pkg for the field widths.
`default_nettype none

interface okvt_req_if;
  logic                                valid;
  logic                                ready;
  logic [okvt_pkg::ACTION_W-1:0]       action;
  logic [okvt_pkg::KEY_FIELD_W-1:0]    key;
  logic [okvt_pkg::VALUE_FIELD_W-1:0]  value;
  logic [okvt_pkg::POS_FIELD_W-1:0]    position;

  modport source (output valid, action, key, value, position, input ready);
  modport sink   (input valid, action, key, value, position, output ready);
endinterface

`default_nettype wire

FILE: src/okvt_rsp_if.sv
// Response channel of the ordered key/value table: valid/ready plus one item.
// Depends on okvt_pkg for the field widths.
`default_nettype none

interface okvt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic [okvt_pkg::KEY_FIELD_W-1:0]    key_out;
  logic [okvt_pkg::VALUE_FIELD_W-1:0]  value_out;
  logic [okvt_pkg::COUNT_FIELD_W-1:0]  entry_count;

  modport source (output valid, ok, key_out, value_out, entry_count, input ready);
  modport sink   (input valid, ok, key_out, value_out, entry_count, output ready);
endinterface

`default_nettype wire

FILE: src/ordered_key_value_table.sv
// Ordered key/value table: every request is looked up against all slots at once,
// the slots shift or update in the accept cycle, and the result is registered.
// The result is valid in the cycle after accept; one item is taken per cycle,
// also while a result waits, as long as the result register is free or drained.
// Reset clears the entry count and the result valid; slot contents are not cleared.
`default_nettype none

module ordered_key_value_table (
  input  wire logic   clk,
  input  wire logic   rst,
  okvt_req_if.sink    req,
  okvt_rsp_if.source  rsp
);

  `include "ordered_key_value_table_assert.svh"

  okvt_pkg::key_t   keys   [okvt_pkg::CAPACITY];
  okvt_pkg::value_t values [okvt_pkg::CAPACITY];
  okvt_pkg::count_t count;
  okvt_pkg::count_t count_next;

  logic                                rsp_valid;
  logic                                rsp_ok;
  logic [okvt_pkg::KEY_FIELD_W-1:0]    rsp_key;
  logic [okvt_pkg::VALUE_FIELD_W-1:0]  rsp_value;
  logic [okvt_pkg::COUNT_FIELD_W-1:0]  rsp_count;

  logic                                acc;
  okvt_pkg::action_t                   act;
  okvt_pkg::key_t                      k;
  okvt_pkg::value_t                    v;
  okvt_pkg::slot_idx_t                 pos_idx;
  logic [okvt_pkg::CMP_W-1:0]          pos_ext;
  logic [okvt_pkg::CMP_W-1:0]          cnt_ext;
  okvt_pkg::slot_mask_t                match;
  okvt_pkg::slot_mask_t                erase_from;
  logic                                found;
  logic                                full;
  okvt_pkg::value_t                    hit_value;
  logic                                do_push;
  logic                                do_update;
  logic                                do_erase;
  logic                                ok_next;
  logic [okvt_pkg::KEY_FIELD_W-1:0]    kout_next;
  logic [okvt_pkg::VALUE_FIELD_W-1:0]  vout_next;

  assign req.ready = !rsp_valid || rsp.ready;
  assign acc       = req.valid && req.ready;

  assign act     = okvt_pkg::action_t'(req.action);
  assign k       = okvt_pkg::key_t'(req.key);
  assign v       = okvt_pkg::value_t'(req.value);
  assign pos_idx = okvt_pkg::SLOT_W'(req.position);
  assign pos_ext = okvt_pkg::CMP_W'(req.position);
  assign cnt_ext = okvt_pkg::CMP_W'(count);
  assign full    = (count == okvt_pkg::CNT_W'(okvt_pkg::CAPACITY));

  // Parallel compare against the occupied slots. Keys are unique, so at most
  // one slot hits and the value can be gathered with a plain OR.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < okvt_pkg::CAPACITY; i++) begin
      match[i] = (okvt_pkg::CNT_W'(i) < count) && (keys[i] == k);
      if (match[i]) begin
        hit_value = hit_value | values[i];
      end
    end
  end

  assign found = |match;

  // A slot at or beyond the erased one takes its older neighbor.
  always_comb begin
    for (int i = 0; i < okvt_pkg::CAPACITY; i++) begin
      erase_from[i] = |(match & ({okvt_pkg::CAPACITY{1'b1}} >> (okvt_pkg::CAPACITY - 1 - i)));
    end
  end

  always_comb begin
    do_push   = 1'b0;
    do_update = 1'b0;
    do_erase  = 1'b0;
    ok_next   = 1'b0;
    kout_next = '0;
    vout_next = '0;
    unique case (act)
      okvt_pkg::ACT_INSERT: begin
        do_push = !found && !full;
        ok_next = do_push;
      end
      okvt_pkg::ACT_UPDATE: begin
        do_update = found;
        ok_next   = found;
      end
      okvt_pkg::ACT_INSERT_OR_UPDATE: begin
        do_update = found;
        do_push   = !found && !full;
        ok_next   = found || !full;
      end
      okvt_pkg::ACT_ERASE: begin
        do_erase = found;
        ok_next  = found;
      end
      okvt_pkg::ACT_CONTAINS: begin
        ok_next = found;
      end
      okvt_pkg::ACT_GET_BY_KEY: begin
        ok_next   = found;
        vout_next = okvt_pkg::VALUE_FIELD_W'(hit_value);
      end
      okvt_pkg::ACT_GET_BY_POSITION: begin
        ok_next = (pos_ext < cnt_ext);
        if (ok_next) begin
          kout_next = okvt_pkg::KEY_FIELD_W'(keys[pos_idx]);
          vout_next = okvt_pkg::VALUE_FIELD_W'(values[pos_idx]);
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_push) begin
      count_next = count + okvt_pkg::CNT_W'(1);
    end else if (do_erase) begin
      count_next = count - okvt_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (acc) begin
      count <= count_next;
    end
  end

  // Slot storage: push shifts everything one place older, erase closes the gap.
  always_ff @(posedge clk) begin
    if (acc) begin
      if (do_push) begin
        keys[0]   <= k;
        values[0] <= v;
        for (int i = 1; i < okvt_pkg::CAPACITY; i++) begin
          keys[i]   <= keys[i-1];
          values[i] <= values[i-1];
        end
      end else if (do_erase) begin
        for (int i = 0; i < okvt_pkg::CAPACITY - 1; i++) begin
          if (erase_from[i]) begin
            keys[i]   <= keys[i+1];
            values[i] <= values[i+1];
          end
        end
      end else if (do_update) begin
        for (int i = 0; i < okvt_pkg::CAPACITY; i++) begin
          if (match[i]) begin
            values[i] <= v;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (acc) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp_ok    <= ok_next;
      rsp_key   <= kout_next;
      rsp_value <= vout_next;
      rsp_count <= okvt_pkg::COUNT_FIELD_W'(count_next);
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.ok          = rsp_ok;
  assign rsp.key_out     = rsp_key;
  assign rsp.value_out   = rsp_value;
  assign rsp.entry_count = rsp_count;

  `OKVT_ASSERT_SAME(a_count_bound, 1'b1, count <= okvt_pkg::CNT_W'(okvt_pkg::CAPACITY))
  `OKVT_ASSERT_SAME(a_unique_hit, 1'b1, $onehot0(match))
  `OKVT_ASSERT_SAME(a_stall_blocks, rsp_valid && !rsp.ready, !req.ready)
  `OKVT_ASSERT_NEXT(a_push_grows, acc && do_push, count == $past(count) + okvt_pkg::CNT_W'(1))
  `OKVT_ASSERT_NEXT(a_erase_shrinks, acc && do_erase, count == $past(count) - okvt_pkg::CNT_W'(1))

endmodule

`default_nettype wire
